// File: rtl/memory_size_probe_sequencer_macros.svh
// Assertion macros shared by the memory size probe sequencer.
`ifndef MEMORY_SIZE_PROBE_SEQUENCER_MACROS_SVH
`define MEMORY_SIZE_PROBE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MSPS_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("memory size probe sequencer: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MSPS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("memory size probe sequencer: next-cycle check failed");

`endif

// File: rtl/msps_pkg.sv
// Types and constants shared by the memory size probe sequencer modules.
package msps_pkg;

  localparam logic [31:0] PATTERN     = 32'haa55aa55;
  localparam logic [31:0] PATTERN_INV = 32'h55aa55aa;

  // Input item kinds carried on tuser.
  localparam logic REQ_START    = 1'b0;
  localparam logic REQ_RESPONSE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RANGE_START   = 2'd0;
  localparam logic [1:0] CFG_RANGE_END     = 2'd1;
  localparam logic [1:0] CFG_PRESERVED_BASE = 2'd2;
  localparam logic [1:0] CFG_PRESERVED_LEN = 2'd3;

  // Probe phases: which read the block is waiting for.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SAVE = 3'd1;
  localparam logic [2:0] PH_INV1 = 3'd2;
  localparam logic [2:0] PH_CHK1 = 3'd3;
  localparam logic [2:0] PH_INV2 = 3'd4;
  localparam logic [2:0] PH_CHK2 = 3'd5;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_DONE  = 2'd2
  } bus_op_t;

  typedef enum logic [1:0] {
    DSEL_ZERO    = 2'd0,
    DSEL_PATTERN = 2'd1,
    DSEL_INV     = 2'd2,
    DSEL_SAVED   = 2'd3
  } data_sel_t;

  typedef enum logic {
    ASEL_PROBE = 1'b0,
    ASEL_BASE  = 1'b1
  } addr_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SAVE,
    S_INV,
    S_RD_LAST,
    S_RESTORE_OK,
    S_RESTORE_BAD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic      latch_in;
    logic      start;
    logic      inc_phase;
    logic      set_phase1;
    logic      save_word;
    logic      skip;
    logic      advance;
    logic      fail;
    logic      finish;
    logic      emit;
    bus_op_t   op;
    data_sel_t dsel;
    addr_sel_t asel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] phase;
    logic       step_valid;
    logic       in_window;
    logic       skip_end;
    logic       adv_end;
    logic       in_pattern;
    logic       in_inverse;
    logic       out_free;
  } status_t;

endpackage

// File: rtl/msps_ctrl.sv
// Controller state machine that sequences the probe accesses.
module msps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tuser,
  output logic              s_tready,
  input  msps_pkg::status_t status,
  output msps_pkg::cmd_t    cmd
);
  import msps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          if (s_tuser == REQ_START) begin
            if (!status.busy) begin
              cmd.start  = 1'b1;
              state_next = S_SEARCH;
            end
          end else if (status.busy) begin
            case (status.phase)
              PH_SAVE: begin
                cmd.inc_phase = 1'b1;
                state_next    = S_SAVE;
              end
              PH_INV1, PH_INV2: begin
                cmd.inc_phase = 1'b1;
                state_next    = S_INV;
              end
              PH_CHK1: begin
                cmd.inc_phase = 1'b1;
                state_next    = status.in_inverse ? S_RD_LAST : S_RESTORE_BAD;
              end
              PH_CHK2: begin
                cmd.inc_phase = 1'b1;
                state_next    = status.in_pattern ? S_RESTORE_OK : S_RESTORE_BAD;
              end
              default: begin
                state_next = S_IDLE;
              end
            endcase
          end
        end
      end
      S_SEARCH: begin
        // One candidate step per cycle; preserved steps are skipped in place.
        if (!status.step_valid) begin
          state_next = S_FINISH;
        end else if (status.in_window) begin
          cmd.skip   = 1'b1;
          state_next = status.skip_end ? S_FINISH : S_SEARCH;
        end else begin
          cmd.set_phase1 = 1'b1;
          state_next     = S_RD_LAST;
        end
      end
      S_SAVE: begin
        if (status.out_free) begin
          cmd.save_word = 1'b1;
          cmd.emit      = 1'b1;
          cmd.op        = OP_WRITE;
          cmd.dsel      = DSEL_PATTERN;
          state_next    = S_RD_LAST;
        end
      end
      S_INV: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.op     = OP_WRITE;
          cmd.dsel   = DSEL_INV;
          state_next = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.op     = OP_READ;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RESTORE_OK: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.op      = OP_WRITE;
          cmd.dsel    = DSEL_SAVED;
          cmd.advance = 1'b1;
          state_next  = status.adv_end ? S_FINISH : S_SEARCH;
        end
      end
      S_RESTORE_BAD: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.op     = OP_WRITE;
          cmd.dsel   = DSEL_SAVED;
          cmd.fail   = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.op     = OP_DONE;
          cmd.asel   = ASEL_BASE;
          cmd.last   = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/msps_dp.sv
// Datapath: configuration, search registers, address arithmetic and output stage.
module msps_dp #(
  parameter int INITIAL_STEP_LOG2 = 30,
  parameter int MIN_STEP_LOG2     = 12,
  parameter int ADDR_WIDTH        = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  msps_pkg::cmd_t    cmd,
  output msps_pkg::status_t status
);
  import msps_pkg::*;

  localparam int AW = ADDR_WIDTH;
  localparam logic [5:0] INIT_LG = 6'(INITIAL_STEP_LOG2);
  localparam logic [5:0] MIN_LG  = 6'(MIN_STEP_LOG2);

  logic [AW-1:0] range_start;
  logic [AW-1:0] range_end;
  logic [AW-1:0] preserved_base;
  logic [31:0]   preserved_length;

  logic          busy;
  logic [2:0]    phase;
  logic [AW-1:0] base;
  logic [AW-1:0] mark;
  logic [3:0]    step_index;
  logic [31:0]   saved_word;
  logic [31:0]   rdata;

  bus_op_t       out_op;
  logic [31:0]   out_addr;
  logic [31:0]   out_data;
  logic          out_last;

  logic [5:0]    dbl;
  logic [5:0]    lg;
  logic [AW:0]   step_wide;
  logic [AW-1:0] step;
  logic [AW-1:0] base_step;
  logic [AW-1:0] probe;
  logic [AW-1:0] win_off;
  logic          out_free;
  logic [31:0]   data_sel;

  assign cfg_ready = 1'b1;

  always_comb begin
    dbl       = {1'b0, step_index, 1'b0};
    lg        = INIT_LG - dbl;
    step_wide = (AW + 1)'(1) << lg[4:0];
    // A step as large as the address space wraps to zero.
    step      = step_wide[AW-1:0];
    base_step = base + step;
    probe     = base_step - AW'(4);
    win_off   = probe - preserved_base;
    out_free  = !m_tvalid || m_tready;

    status.busy       = busy;
    status.phase      = phase;
    status.step_valid = (dbl <= INIT_LG) && (lg >= MIN_LG);
    status.in_window  = (preserved_length != 32'd0) && (probe >= preserved_base) &&
                        (32'(win_off) < preserved_length);
    // Coming back to the base where this walk began means a full wrap.
    status.skip_end   = (base_step > range_end) || (base_step == mark);
    status.adv_end    = base_step > range_end;
    status.in_pattern = s_tdata == PATTERN;
    status.in_inverse = s_tdata == PATTERN_INV;
    status.out_free   = out_free;

    case (cmd.dsel)
      DSEL_PATTERN: data_sel = PATTERN;
      DSEL_INV:     data_sel = ~rdata;
      DSEL_SAVED:   data_sel = saved_word;
      default:      data_sel = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start      <= '0;
      range_end        <= '0;
      preserved_base   <= '0;
      preserved_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RANGE_START:    range_start      <= cfg_data[AW-1:0];
        CFG_RANGE_END:      range_end        <= cfg_data[AW-1:0];
        CFG_PRESERVED_BASE: preserved_base   <= cfg_data[AW-1:0];
        CFG_PRESERVED_LEN:  preserved_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      phase      <= PH_IDLE;
      base       <= '0;
      mark       <= '0;
      step_index <= '0;
      saved_word <= '0;
    end else begin
      if (cmd.start) begin
        busy       <= 1'b1;
        phase      <= PH_IDLE;
        base       <= range_start;
        mark       <= range_start;
        step_index <= '0;
      end
      if (cmd.inc_phase) begin
        phase <= phase + 3'd1;
      end
      if (cmd.set_phase1) begin
        phase <= PH_SAVE;
      end
      if (cmd.save_word) begin
        saved_word <= rdata;
      end
      if (cmd.skip) begin
        base <= base_step;
      end
      if (cmd.advance) begin
        base <= base_step;
        mark <= base_step;
      end
      if (cmd.fail) begin
        step_index <= step_index + 4'd1;
        mark       <= base;
      end
      if (cmd.finish) begin
        busy  <= 1'b0;
        phase <= PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      rdata <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_op   <= cmd.op;
      out_addr <= (cmd.asel == ASEL_BASE) ? 32'(base) : 32'(probe);
      out_data <= data_sel;
      out_last <= cmd.last;
    end
  end

  assign m_tdata = {out_data, out_addr};
  assign m_tuser = out_op;
  assign m_tlast = out_last;

endmodule

// File: rtl/memory_size_probe_sequencer.sv
// Top level of the memory size probe sequencer: controller, datapath and checks.
//
//  Channel   Direction  Handshake             Contents
//  s_*       in         s_tvalid / s_tready   start request or read response
//  m_*       out        m_tvalid / m_tready   bus request or search result
//  cfg_*     in         cfg_valid / cfg_ready register write by index
//
// An input is taken only in the idle state; a start then walks the search loop
// over the candidate steps before its results go out. A read response yields
// one or two results; one that ends a probe also walks the search loop after
// the restore write. Each result waits for the single output register to be free.
// Reset is synchronous: the control, search and configuration registers clear
// to zero and the block goes idle; read data and output payload are not reset.
`include "memory_size_probe_sequencer_macros.svh"

module memory_size_probe_sequencer #(
  parameter int INITIAL_STEP_LOG2 = 30,
  parameter int MIN_STEP_LOG2     = 12,
  parameter int ADDR_WIDTH        = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // read_data
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // bus_address, write_data
  output logic [1:0]  m_tuser,   // bus_op
  output logic        m_tlast,   // final_item
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import msps_pkg::*;

  cmd_t    cmd;
  status_t status;

  msps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  msps_dp #(
    .INITIAL_STEP_LOG2 (INITIAL_STEP_LOG2),
    .MIN_STEP_LOG2     (MIN_STEP_LOG2),
    .ADDR_WIDTH        (ADDR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  `MSPS_ASSERT_SAME(a_emit_when_free, cmd.emit, status.out_free)
  `MSPS_ASSERT_SAME(a_read_is_last, m_tvalid && (m_tuser == OP_READ), m_tlast)
  `MSPS_ASSERT_SAME(a_data_zero, m_tvalid && (m_tuser != OP_WRITE), m_tdata[63:32] == 32'd0)
  `MSPS_ASSERT_NEXT(a_start_leaves_idle, s_tvalid && s_tready && (s_tuser == REQ_START) && !status.busy, !s_tready)

endmodule
